// ===== rtl/cnv3_pkg.sv =====
package cnv3_pkg;

	// fixed field widths
	localparam int PIX_W      = 8;
	localparam int ROW_W      = 16;
	localparam int COL_W      = 10;
	localparam int SUM_W      = 20;
	localparam int PROD_W     = 17;
	localparam int ROWSUM_W   = 19;
	localparam int COEF_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 16;

	// smallest image side the window needs
	localparam int MIN_DIM = 3;

	// largest clamped output value
	localparam int PIX_MAX = 255;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_MIDDLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOTTOM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT  = 3'd4;

	// configuration reset values (sharpen mask, 640x480)
	localparam logic [CFG_DATA_W-1:0] COEF_TOP_RST    = 24'h00FF00;
	localparam logic [CFG_DATA_W-1:0] COEF_MIDDLE_RST = 24'hFF05FF;
	localparam logic [CFG_DATA_W-1:0] COEF_BOTTOM_RST = 24'h00FF00;
	localparam logic [IMG_W_W-1:0]    IMG_WIDTH_RST   = 11'd640;
	localparam logic [IMG_H_W-1:0]    IMG_HEIGHT_RST  = 16'd480;

	// 3x3 window of pixels, [row][col], row 0 is the oldest line
	typedef logic [2:0][2:0][PIX_W-1:0] cnv3_win_t;

	// 3x3 signed coefficients, [row][col]
	typedef logic [2:0][2:0][COEF_W-1:0] cnv3_coef_t;

	// position info that rides along with a window
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} cnv3_tag_t;

endpackage

// ===== rtl/cnv3_mac.sv =====
module cnv3_mac
	import cnv3_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    win_valid,
	input  cnv3_tag_t               win_tag,
	input  cnv3_win_t               win,
	input  cnv3_coef_t              coef,
	output logic                    res_valid,
	output cnv3_tag_t               res_tag,
	output logic signed [SUM_W-1:0] res_sum,
	output logic [PIX_W-1:0]        res_clamp
);

	logic                       v_s1, v_s2, v_s3;
	cnv3_tag_t                  tag_s1, tag_s2, tag_s3;
	logic signed [PROD_W-1:0]   prod_s1 [3][3];
	logic signed [ROWSUM_W-1:0] rsum_s2 [3];
	logic signed [SUM_W-1:0]    sum_s3;
	logic [PIX_W-1:0]           clamp_s3;
	logic signed [SUM_W-1:0]    total;
	logic [PIX_W-1:0]           clamp;

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= win_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// nine products, coefficient signed, pixel unsigned
	always_ff @(posedge clk) begin
		tag_s1 <= win_tag;
		for (int y = 0; y < 3; y++) begin
			for (int x = 0; x < 3; x++) begin
				prod_s1[y][x] <= $signed(coef[y][x]) * $signed({1'b0, win[y][x]});
			end
		end
	end

	// per-row sums
	always_ff @(posedge clk) begin
		tag_s2 <= tag_s1;
		for (int y = 0; y < 3; y++) begin
			rsum_s2[y] <= ROWSUM_W'(prod_s1[y][0]) + ROWSUM_W'(prod_s1[y][1])
				+ ROWSUM_W'(prod_s1[y][2]);
		end
	end

	// final sum and saturation to pixel range
	always_comb begin
		total = SUM_W'(rsum_s2[0]) + SUM_W'(rsum_s2[1]) + SUM_W'(rsum_s2[2]);
		if (total[SUM_W-1]) begin
			clamp = '0;
		end else if (total > SUM_W'(PIX_MAX)) begin
			clamp = PIX_W'(PIX_MAX);
		end else begin
			clamp = total[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		tag_s3   <= tag_s2;
		sum_s3   <= total;
		clamp_s3 <= clamp;
	end

	assign res_valid = v_s3;
	assign res_tag   = tag_s3;
	assign res_sum   = sum_s3;
	assign res_clamp = clamp_s3;

endmodule

// ===== rtl/conv3x3_sharpen_filter_top.sv =====
// 3x3 convolution over a raster stream of 8-bit grayscale pixels.
// Input channel: in_valid / in_stall with pixel and frame_start; frame_start
// puts that pixel at row 0, column 0. Output channel: out_valid / out_stall
// with centre_row, centre_col, weighted_sum, clamped_pixel and frame_last.
// Only interior pixels produce a result; border pixels produce none.
// Configuration: cfg_valid / cfg_ready (always ready) with cfg_index and
// cfg_data; write mask rows, width and height only while the block is idle.
// Throughput: one pixel per clock while in_stall is low. Both previous lines sit in one
// 16-bit wide line memory that is read and written back once per pixel, so one
// memory access pair per cycle sets the rate.
// Path: a result passes memory read, window update, multiply, row sums, final
// sum and clamp, then the result queue, before it shows on out_valid.
// An 8-entry result queue sits in front of the output. The input stalls once
// results in flight plus queued results reach 8, so a stalled receiver holds
// the queue and the input stops before the queue can overflow.
// Reset: position counters go to zero and registers to their defaults
// (sharpen mask, 640x480); the line memory needs no clearing pass.
module conv3x3_sharpen_filter_top
	import cnv3_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [PIX_W-1:0]        pixel,
	input  logic                    frame_start,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [ROW_W-1:0]        centre_row,
	output logic [COL_W-1:0]        centre_col,
	output logic signed [SUM_W-1:0] weighted_sum,
	output logic [PIX_W-1:0]        clamped_pixel,
	output logic                    frame_last
);

	localparam int CW         = $clog2(MAX_WIDTH);
	localparam int WW         = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
	localparam int FIFO_DEPTH = 8;
	localparam int FP_W       = $clog2(FIFO_DEPTH);
	localparam int FC_W       = FP_W + 1;

	typedef struct packed {
		cnv3_tag_t               tag;
		logic signed [SUM_W-1:0] sum;
		logic [PIX_W-1:0]        clamp;
	} res_t;

	// configuration registers
	logic [CFG_DATA_W-1:0] coef_top_q, coef_mid_q, coef_bot_q;
	logic [IMG_W_W-1:0]    img_width_q;
	logic [IMG_H_W-1:0]    img_height_q;

	// position counters
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	// stage 0 position logic
	logic             in_acc;
	logic [WW-1:0]    w_raw, width_eff;
	logic [ROW_W-1:0] height_eff;
	logic [CW-1:0]    col_a, c0;
	logic [ROW_W-1:0] row_a, row_b, r0;
	logic             wrap_pre;
	logic             produce0, last0;
	logic [WW-1:0]    c_inc;
	logic [CW-1:0]    col_n, c_m1;
	logic [ROW_W-1:0] row_n, r_inc;
	logic             fwd0;

	// line memory: {older, newer} per column
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rdata_q;

	// stage 1
	logic               v_s1, prod_s1, fwd_s1;
	logic [PIX_W-1:0]   px_s1;
	logic [CW-1:0]      c_s1;
	cnv3_tag_t          tag_s1;
	logic [2*PIX_W-1:0] fwd_data_s1;
	logic [2*PIX_W-1:0] line_s1;

	// window and stage 2
	cnv3_win_t  win_q;
	logic       v_s2;
	cnv3_tag_t  tag_s2;
	cnv3_coef_t coef;

	// mac results
	logic                    mac_valid;
	cnv3_tag_t               mac_tag;
	logic signed [SUM_W-1:0] mac_sum;
	logic [PIX_W-1:0]        mac_clamp;

	// result queue
	res_t            fifo_q [FIFO_DEPTH];
	logic [FP_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FC_W-1:0] fcnt_q, credit_q;
	logic            pop;
	res_t            head;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_top_q   <= COEF_TOP_RST;
			coef_mid_q   <= COEF_MIDDLE_RST;
			coef_bot_q   <= COEF_BOTTOM_RST;
			img_width_q  <= IMG_WIDTH_RST;
			img_height_q <= IMG_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_COEF_TOP:    coef_top_q   <= cfg_data;
				CFG_COEF_MIDDLE: coef_mid_q   <= cfg_data;
				CFG_COEF_BOTTOM: coef_bot_q   <= cfg_data;
				CFG_IMG_WIDTH:   img_width_q  <= cfg_data[IMG_W_W-1:0];
				CFG_IMG_HEIGHT:  img_height_q <= cfg_data[IMG_H_W-1:0];
				default: ;
			endcase
		end
	end

	// saturated frame dimensions
	always_comb begin
		w_raw = WW'(img_width_q);
		if (w_raw < WW'(MIN_DIM)) begin
			width_eff = WW'(MIN_DIM);
		end else if (w_raw > WW'(MAX_WIDTH)) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = w_raw;
		end
		height_eff = (img_height_q < IMG_H_W'(MIN_DIM)) ? IMG_H_W'(MIN_DIM) : img_height_q;
	end

	// current pixel position and next counter values
	always_comb begin
		col_a    = frame_start ? '0 : col_q;
		row_a    = frame_start ? '0 : row_q;
		wrap_pre = WW'(col_a) >= width_eff;
		c0       = wrap_pre ? '0 : col_a;
		row_b    = wrap_pre ? row_a + 1'b1 : row_a;
		r0       = (row_b >= height_eff) ? '0 : row_b;

		produce0 = (r0 >= ROW_W'(2)) && (WW'(c0) >= WW'(2));
		last0    = (r0 == height_eff - 1'b1) && (WW'(c0) == width_eff - 1'b1);
		c_m1     = c0 - 1'b1;

		c_inc = WW'(c0) + 1'b1;
		r_inc = r0 + 1'b1;
		if (c_inc >= width_eff) begin
			col_n = '0;
			row_n = (r_inc >= height_eff) ? '0 : r_inc;
		end else begin
			col_n = c_inc[CW-1:0];
			row_n = r0;
		end
	end

	assign in_acc = in_valid && !in_stall;
	assign in_stall = credit_q >= FC_W'(FIFO_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			col_q <= col_n;
			row_q <= row_n;
		end
	end

	// read of the line memory, with forwarding when stage 1 writes the same column
	assign fwd0 = v_s1 && (c_s1 == c0);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rdata_q <= line_mem[c0];
		end
		if (v_s1) begin
			line_mem[c_s1] <= {line_s1[PIX_W-1:0], px_s1};
		end
	end

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			prod_s1     <= produce0;
			px_s1       <= pixel;
			c_s1        <= c0;
			fwd_s1      <= fwd0;
			fwd_data_s1 <= {line_s1[PIX_W-1:0], px_s1};
			tag_s1.row  <= r0 - 1'b1;
			tag_s1.col  <= COL_W'(c_m1);
			tag_s1.last <= last0;
		end
	end

	assign line_s1 = fwd_s1 ? fwd_data_s1 : rdata_q;

	// window shift: new column enters on the right
	always_ff @(posedge clk) begin
		if (v_s1) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
			end
			win_q[0][2] <= line_s1[2*PIX_W-1:PIX_W];
			win_q[1][2] <= line_s1[PIX_W-1:0];
			win_q[2][2] <= px_s1;
			tag_s2      <= tag_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && prod_s1;
		end
	end

	// coefficient rows into the [row][col] layout
	assign coef[0] = coef_top_q;
	assign coef[1] = coef_mid_q;
	assign coef[2] = coef_bot_q;

	cnv3_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_valid (v_s2),
		.win_tag   (tag_s2),
		.win       (win_q),
		.coef      (coef),
		.res_valid (mac_valid),
		.res_tag   (mac_tag),
		.res_sum   (mac_sum),
		.res_clamp (mac_clamp)
	);

	// result queue and credit count
	assign pop = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fcnt_q   <= '0;
			credit_q <= '0;
		end else begin
			if (mac_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fcnt_q   <= fcnt_q + FC_W'(mac_valid) - FC_W'(pop);
			credit_q <= credit_q + FC_W'(in_acc && produce0) - FC_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (mac_valid) begin
			fifo_q[wr_ptr_q] <= '{tag: mac_tag, sum: mac_sum, clamp: mac_clamp};
		end
	end

	// output drive from queue head
	assign head          = fifo_q[rd_ptr_q];
	assign out_valid     = fcnt_q != '0;
	assign centre_row    = head.tag.row;
	assign centre_col    = head.tag.col;
	assign frame_last    = head.tag.last;
	assign weighted_sum  = head.sum;
	assign clamped_pixel = head.clamp;

	// checks
	a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(mac_valid && !pop) |-> (fcnt_q < FC_W'(FIFO_DEPTH)))
		else $error("result queue overflow");

	a_credit_covers_queue: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= credit_q)
		else $error("queued results exceed credit count");

	a_s1_from_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(in_valid && !in_stall))
		else $error("stage 1 valid without input transfer");

endmodule
